// ----- design/mwf_pkg.sv -----
// Shared types and constants for the median window filter.
package mwf_pkg;

  localparam int PIX_W     = 8;
  localparam int ROW_W     = 12;
  localparam int COL_OUT_W = 11;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

  // Tag that travels with each pixel down the pipeline
  typedef struct packed {
    logic                 res;   // window is complete and inside the image
    logic                 last;  // bottom-right pixel of the frame
    logic [ROW_W-1:0]     row;   // centre row
    logic [COL_OUT_W-1:0] col;   // centre column
  } pos_t;

endpackage

// ----- design/mwf_line_buf.sv -----
// Line store: one entry per column, one byte lane per buffered row.
module mwf_line_buf #(
  parameter int SIDE  = 3,
  parameter int DEPTH = 2048,
  localparam int SLOT_W = $clog2(SIDE),
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [ADDR_W-1:0]                   addr,
  input  logic [SLOT_W-1:0]                   lane,
  input  logic [mwf_pkg::PIX_W-1:0]           pixel,
  output logic [SIDE-1:0][mwf_pkg::PIX_W-1:0] rd_lanes
);
  import mwf_pkg::*;

  logic [SIDE-1:0][PIX_W-1:0] mem [DEPTH];

  // Only the lane of the current row is written; the other lanes are read
  // back the same cycle, so the same entry never needs forwarding.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int l = 0; l < SIDE; l++) begin
        if (lane == SLOT_W'(l)) begin
          mem[addr][l] <= pixel;
        end
      end
      rd_lanes <= mem[addr];
    end
  end

endmodule

// ----- design/mwf_window.sv -----
// Column assembly from the line store and the sliding window registers.
module mwf_window #(
  parameter int SIDE = 3,
  localparam int SLOT_W = $clog2(SIDE),
  localparam int AREA   = SIDE * SIDE
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  output logic                                ready_up,
  input  logic [mwf_pkg::PIX_W-1:0]           pixel,
  input  logic [SLOT_W-1:0]                   slot,
  input  mwf_pkg::pos_t                       pos,
  input  logic [SIDE-1:0][mwf_pkg::PIX_W-1:0] rd_lanes,
  output logic                                win_valid,
  input  logic                                win_ready,
  output logic [AREA-1:0][mwf_pkg::PIX_W-1:0] win_data,
  output mwf_pkg::pos_t                       win_pos
);
  import mwf_pkg::*;

  // lane holding the row d rows above the current one
  function automatic logic [SLOT_W-1:0] lane_back(input logic [SLOT_W-1:0] s,
                                                  input int d);
    if (int'(s) >= d) begin
      return SLOT_W'(int'(s) - d);
    end
    return SLOT_W'(int'(s) + SIDE - d);
  endfunction

  logic                        s1_valid;
  logic [PIX_W-1:0]            s1_pixel;
  logic [SLOT_W-1:0]           s1_slot;
  pos_t                        s1_pos;
  logic                        s2_valid;
  pos_t                        s2_pos;
  logic [SIDE-1:0][SIDE-1:0][PIX_W-1:0] win;

  logic                        s1_adv;
  logic                        s2_adv;
  logic                        s2_ready;
  logic [SIDE-1:0][PIX_W-1:0]  col_vals;

  // Every pixel shifts the window; only complete windows go on to the sorter.
  assign s2_adv   = s2_valid && (!s2_pos.res || win_ready);
  assign s2_ready = !s2_valid || s2_adv;
  assign s1_adv   = s1_valid && s2_ready;
  assign ready_up = !s1_valid || s2_ready;

  // index 0 is the oldest row, the top one the pixel just taken
  always_comb begin
    for (int j = 0; j < SIDE; j++) begin
      if (j == SIDE - 1) begin
        col_vals[j] = s1_pixel;
      end else begin
        col_vals[j] = rd_lanes[lane_back(s1_slot, SIDE - 1 - j)];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (ready_up) begin
        s1_valid <= load;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
    end
    if (load) begin
      s1_pixel <= pixel;
      s1_slot  <= slot;
      s1_pos   <= pos;
    end
    if (s1_adv) begin
      s2_pos <= s1_pos;
      for (int r = 0; r < SIDE; r++) begin
        for (int c = 0; c < SIDE - 1; c++) begin
          win[r][c] <= win[r][c+1];
        end
        win[r][SIDE-1] <= col_vals[r];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < SIDE; r++) begin
      for (int c = 0; c < SIDE; c++) begin
        win_data[r*SIDE+c] = win[r][c];
      end
    end
  end

  assign win_valid = s2_valid && s2_pos.res;
  assign win_pos   = s2_pos;

endmodule

// ----- design/mwf_sort_net.sv -----
// Pipelined odd-even transposition sort; the last stage is the output register.
module mwf_sort_net #(
  parameter int N = 9
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [N-1:0][mwf_pkg::PIX_W-1:0] in_data,
  input  mwf_pkg::pos_t                    in_pos,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mwf_pkg::PIX_W-1:0]        median,
  output mwf_pkg::pos_t                    out_pos
);
  import mwf_pkg::*;

  logic [N-1:0][PIX_W-1:0] st_data [N];
  pos_t                    st_pos  [N];
  logic                    st_valid[N];
  logic                    st_ready[N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [N-1:0][PIX_W-1:0] prev;
    logic [N-1:0][PIX_W-1:0] swapped;
    logic                    up_valid;
    pos_t                    up_pos;

    if (k == 0) begin : g_first
      assign prev     = in_data;
      assign up_valid = in_valid;
      assign up_pos   = in_pos;
    end else begin : g_next
      assign prev     = st_data[k-1];
      assign up_valid = st_valid[k-1];
      assign up_pos   = st_pos[k-1];
    end

    if (k == N - 1) begin : g_tail
      assign st_ready[k] = !st_valid[k] || out_ready;
    end else begin : g_body
      assign st_ready[k] = !st_valid[k] || st_ready[k+1];
    end

    // even stages pair (0,1),(2,3)..., odd stages pair (1,2),(3,4)...
    always_comb begin
      swapped = prev;
      for (int i = k % 2; i < N - 1; i += 2) begin
        if (prev[i] > prev[i+1]) begin
          swapped[i]   = prev[i+1];
          swapped[i+1] = prev[i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k] <= 1'b0;
      end else if (st_ready[k]) begin
        st_valid[k] <= up_valid;
      end
      if (st_ready[k] && up_valid) begin
        st_data[k] <= swapped;
        st_pos[k]  <= up_pos;
      end
    end
  end

  assign in_ready  = st_ready[0];
  assign out_valid = st_valid[N-1];
  assign median    = st_data[N-1][N/2];
  assign out_pos   = st_pos[N-1];

  a_median_ordered : assert property (@(posedge clk) disable iff (rst)
    st_valid[N-1] |-> (st_data[N-1][N/2-1] <= st_data[N-1][N/2]) &&
                      (st_data[N-1][N/2] <= st_data[N-1][N/2+1]))
    else $error("sorter output not ordered around the median");

endmodule

// ----- design/median_window_filter.sv -----
// Top level of the square-window median filter.
//
// Takes one 8-bit pixel per clock in raster order while in_ready is high, and
// returns, for each pixel whose (2R+1)x(2R+1) window lies inside the image,
// the window median with the centre pixel's row and column; frame_last marks
// the bottom-right result. Sustained rate is one pixel per clock while
// out_ready stays high: the line store takes one write and one read per
// transfer, and the sorter is a pipeline of (2R+1)^2 compare stages. Each
// pixel goes through the line store read, the window shift and then the sort
// stages. The last sort stage is the output register; while it is held, input
// is still taken until the bubbles in the pipeline are filled. The line store
// needs no clearing pass after reset. image_width and image_height are to be
// changed only between frames.
module median_window_filter #(
  parameter int WINDOW_RADIUS = 1,
  parameter int MAX_WIDTH     = 2048
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [mwf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mwf_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mwf_pkg::PIX_W-1:0]       pixel,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mwf_pkg::PIX_W-1:0]       median_value,
  output logic [mwf_pkg::ROW_W-1:0]       centre_row,
  output logic [mwf_pkg::COL_OUT_W-1:0]   centre_col,
  output logic                            frame_last
);
  import mwf_pkg::*;

  localparam int SIDE   = 2 * WINDOW_RADIUS + 1;
  localparam int AREA   = SIDE * SIDE;
  localparam int SLOT_W = $clog2(SIDE);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int EFF_W  = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W  = (EFF_W > CFG_W + 1) ? EFF_W : CFG_W + 1;

  logic [CFG_W-1:0]  image_width;
  logic [CFG_W-1:0]  image_height;
  logic [ROW_W-1:0]  row_count;
  logic [COL_W-1:0]  col_count;
  logic [SLOT_W-1:0] slot;       // row_count modulo the window side

  logic              accept;
  logic [CMP_W-1:0]  eff_w;
  logic [CMP_W-1:0]  eff_h;
  logic [CMP_W-1:0]  col_ext;
  logic [CMP_W-1:0]  row_ext;
  logic              col_wrap;
  logic              row_wrap;
  pos_t              pos;

  logic [SIDE-1:0][PIX_W-1:0] rd_lanes;
  logic                       win_valid;
  logic                       win_ready;
  logic [AREA-1:0][PIX_W-1:0] win_data;
  pos_t                       win_pos;
  pos_t                       out_pos;

  assign accept = in_valid && in_ready;

  // zero size reads as one, width clamps to the line store depth
  always_comb begin
    eff_w = CMP_W'(image_width);
    if (image_width == '0) begin
      eff_w = CMP_W'(1);
    end else if (CMP_W'(image_width) > CMP_W'(MAX_WIDTH)) begin
      eff_w = CMP_W'(MAX_WIDTH);
    end
    eff_h = (image_height == '0) ? CMP_W'(1) : CMP_W'(image_height);
  end

  assign col_ext  = CMP_W'(col_count);
  assign row_ext  = CMP_W'(row_count);
  assign col_wrap = (col_ext + CMP_W'(1)) >= eff_w;
  assign row_wrap = (row_ext + CMP_W'(1)) >= eff_h;

  always_comb begin
    pos.res  = (row_ext < eff_h) && (col_ext < eff_w) &&
               (row_ext >= CMP_W'(SIDE - 1)) && (col_ext >= CMP_W'(SIDE - 1));
    pos.last = (row_ext == eff_h - CMP_W'(1)) && (col_ext == eff_w - CMP_W'(1));
    pos.row  = row_count - ROW_W'(WINDOW_RADIUS);
    pos.col  = COL_OUT_W'(col_ext - CMP_W'(WINDOW_RADIUS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
        CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
      slot      <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col_count <= '0;
        if (row_wrap) begin
          row_count <= '0;
          slot      <= '0;
        end else begin
          row_count <= row_count + 1'b1;
          slot      <= (slot == SLOT_W'(SIDE - 1)) ? '0 : slot + 1'b1;
        end
      end else begin
        col_count <= col_count + 1'b1;
      end
    end
  end

  mwf_line_buf #(
    .SIDE  (SIDE),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk      (clk),
    .wr_en    (accept),
    .addr     (col_count),
    .lane     (slot),
    .pixel    (pixel),
    .rd_lanes (rd_lanes)
  );

  mwf_window #(
    .SIDE (SIDE)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .ready_up  (in_ready),
    .pixel     (pixel),
    .slot      (slot),
    .pos       (pos),
    .rd_lanes  (rd_lanes),
    .win_valid (win_valid),
    .win_ready (win_ready),
    .win_data  (win_data),
    .win_pos   (win_pos)
  );

  mwf_sort_net #(
    .N (AREA)
  ) u_sort_net (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (win_valid),
    .in_ready  (win_ready),
    .in_data   (win_data),
    .in_pos    (win_pos),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .median    (median_value),
    .out_pos   (out_pos)
  );

  assign centre_row = out_pos.row;
  assign centre_col = out_pos.col;
  assign frame_last = out_pos.last;

  a_frame_wrap : assert property (@(posedge clk) disable iff (rst)
    accept && col_wrap && row_wrap |=>
      (row_count == '0) && (col_count == '0) && (slot == '0))
    else $error("counters did not wrap at end of frame");

  a_col_step : assert property (@(posedge clk) disable iff (rst)
    accept && !col_wrap |=>
      (col_count == $past(col_count) + 1'b1) && (row_count == $past(row_count)) &&
      (slot == $past(slot)))
    else $error("column step disturbed row state");

  a_slot_row0 : assert property (@(posedge clk) disable iff (rst)
    (row_count == '0) |-> (slot == '0))
    else $error("row slot out of step with row counter");

endmodule
